// ===== src/gtwp_pkg.sv =====
// Shared types, constants, microcode table and helpers for the greedy two-way partition core.
`timescale 1ns / 1ps

package gtwp_pkg;

    // Sizing
    localparam int MAX_ITEMS  = 32;
    localparam int VALUE_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_ITEMS);
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W      = 21;
    localparam int SUM_XW     = SUM_W + 1;

    // Item in / result out
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  last;
    } gtwp_in_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] sorted_value;
        logic                  group;
        logic [SUM_W-1:0]      sum_p;
        logic [SUM_W-1:0]      sum_q;
        logic [SUM_W-1:0]      difference;
        logic                  overflow;
        logic                  end_of_set;
    } gtwp_out_t;

    // Microcode step addresses
    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_INIT  = 3'd1;
    localparam logic [2:0] ST_CAPT  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_SUM   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;
    localparam logic [2:0] ST_CLEAR = 3'd6;

    // Datapath operations
    localparam logic [2:0] OP_LOAD  = 3'd0;
    localparam logic [2:0] OP_INIT  = 3'd1;
    localparam logic [2:0] OP_CAPT  = 3'd2;
    localparam logic [2:0] OP_SCAN  = 3'd3;
    localparam logic [2:0] OP_SUM   = 3'd4;
    localparam logic [2:0] OP_EMIT  = 3'd5;
    localparam logic [2:0] OP_CLEAR = 3'd6;
    localparam logic [2:0] OP_NOP   = 3'd7;

    typedef struct packed {
        logic       ready;
        logic [2:0] op;
        logic [2:0] cnd;
        logic [2:0] t_true;
        logic [2:0] t_false;
    } gtwp_uword_t;

    // Jump conditions
    localparam logic [2:0] CW_ALWAYS   = 3'd0;
    localparam logic [2:0] CW_ACC_LAST = 3'd1;
    localparam logic [2:0] CW_J_END    = 3'd2;
    localparam logic [2:0] CW_J_NEXT   = 3'd3;
    localparam logic [2:0] CW_I_LAST   = 3'd4;

    // Control store: one word per step
    function automatic gtwp_uword_t ucode(input logic [2:0] step);
        gtwp_uword_t w;
        w = '{ready: 1'b0, op: OP_NOP, cnd: CW_ALWAYS, t_true: ST_LOAD, t_false: ST_LOAD};
        unique case (step)
            ST_LOAD:  w = '{1'b1, OP_LOAD,  CW_ACC_LAST, ST_INIT,  ST_LOAD};
            ST_INIT:  w = '{1'b0, OP_INIT,  CW_ALWAYS,   ST_CAPT,  ST_CAPT};
            ST_CAPT:  w = '{1'b0, OP_CAPT,  CW_J_END,    ST_SUM,   ST_SCAN};
            ST_SCAN:  w = '{1'b0, OP_SCAN,  CW_J_NEXT,   ST_SUM,   ST_SCAN};
            ST_SUM:   w = '{1'b0, OP_SUM,   CW_ALWAYS,   ST_EMIT,  ST_EMIT};
            ST_EMIT:  w = '{1'b0, OP_EMIT,  CW_I_LAST,   ST_CLEAR, ST_INIT};
            ST_CLEAR: w = '{1'b0, OP_CLEAR, CW_ALWAYS,   ST_LOAD,  ST_LOAD};
            default:  w = '{1'b0, OP_NOP,   CW_ALWAYS,   ST_CLEAR, ST_CLEAR};
        endcase
        return w;
    endfunction

    // Add with saturation at the top of the sum range
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [VALUE_BITS-1:0] b);
        logic [SUM_XW-1:0] s;
        s = {1'b0, a} + SUM_XW'(b);
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

// ===== src/gtwp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gtwp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/greedy_two_way_partition_core.sv =====
// Top level of the greedy two-way partition core: microcode sequencer and datapath.
`timescale 1ns / 1ps

// Greedy two-way partition core. Items (value, last) are taken one per cycle
// while busy is low; each value goes into a 32-entry store, and values beyond
// that are dropped and reported through the overflow bit of every result of
// the set. An item marked last ends the set: busy rises and the core deals the
// held values out in descending order, the largest remaining value going to
// group P when P's sum is not above Q's, else to Q. Each value yields one
// result, shown for a single cycle with result_valid high; the receiver has no
// way to hold it off and must take it then. For a set of n held values, pass i
// (from 0) scans the remaining n-i values through the store's single read port:
// it fetches the head of the unsorted part, scans the rest for the largest
// value, moves the head into that value's slot, adds the value to a group and
// emits the result. After the last pass a clearing step runs, after which busy
// drops and the count, sums and drop flag are cleared. The block is run by a
// seven-word control store stepping a plain datapath.
module greedy_two_way_partition_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  gtwp_pkg::gtwp_in_t  item,
    output logic                result_valid,
    output gtwp_pkg::gtwp_out_t result
);

    import gtwp_pkg::*;

    // Sequencer
    logic [2:0]  step_reg, step_next;
    gtwp_uword_t uw;
    logic        accept;
    logic        taken;

    // Datapath registers
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      i_reg, i_next;
    logic [CNT_W-1:0]      j_reg, j_next;
    logic [SUM_W-1:0]      p_reg, p_next;
    logic [SUM_W-1:0]      q_reg, q_next;
    logic                  dropped_reg, dropped_next;
    logic [VALUE_BITS-1:0] best_reg, best_next;
    logic [VALUE_BITS-1:0] vi_reg, vi_next;
    logic [IDX_W-1:0]      bidx_reg, bidx_next;
    logic                  grp_reg, grp_next;
    logic                  valid_reg, valid_next;
    gtwp_out_t             res_reg, res_next;

    // Store port
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;

    logic [CNT_W-1:0] j_inc;
    logic [CNT_W-1:0] i_inc;

    assign uw     = ucode(step_reg);
    assign busy   = !uw.ready;
    assign accept = start && uw.ready;
    assign j_inc  = j_reg + CNT_W'(1);
    assign i_inc  = i_reg + CNT_W'(1);

    assign result_valid = valid_reg;
    assign result       = res_reg;

    gtwp_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Branch condition and next step
    always_comb
    begin
        unique case (uw.cnd)
            CW_ALWAYS:   taken = 1'b1;
            CW_ACC_LAST: taken = accept && item.last;
            CW_J_END:    taken = (j_reg == count_reg);
            CW_J_NEXT:   taken = (j_inc == count_reg);
            CW_I_LAST:   taken = (i_inc == count_reg);
            default:     taken = 1'b1;
        endcase
        step_next = taken ? uw.t_true : uw.t_false;
    end

    // Datapath
    always_comb
    begin
        count_next   = count_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        dropped_next = dropped_reg;
        best_next    = best_reg;
        vi_next      = vi_reg;
        bidx_next    = bidx_reg;
        grp_next     = grp_reg;
        valid_next   = 1'b0;
        res_next     = res_reg;
        ram_we       = 1'b0;
        ram_waddr    = bidx_reg;
        ram_wdata    = vi_reg;
        ram_raddr    = i_reg[IDX_W-1:0];

        unique case (uw.op)
            OP_LOAD:
            begin
                if (accept)
                begin
                    if (count_reg < CNT_W'(MAX_ITEMS))
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[IDX_W-1:0];
                        ram_wdata  = item.value;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
            end
            OP_INIT:
            begin
                // fetch the head of the unsorted part
                ram_raddr = i_reg[IDX_W-1:0];
                j_next    = i_inc;
            end
            OP_CAPT:
            begin
                vi_next   = ram_rdata;
                best_next = ram_rdata;
                bidx_next = i_reg[IDX_W-1:0];
                ram_raddr = j_reg[IDX_W-1:0];
            end
            OP_SCAN:
            begin
                // data on the port belongs to j_reg
                if (ram_rdata > best_reg)
                begin
                    best_next = ram_rdata;
                    bidx_next = j_reg[IDX_W-1:0];
                end
                j_next    = j_inc;
                ram_raddr = j_inc[IDX_W-1:0];
            end
            OP_SUM:
            begin
                // old head moves into the slot the maximum came from
                ram_we    = 1'b1;
                ram_waddr = bidx_reg;
                ram_wdata = vi_reg;
                if (p_reg <= q_reg)
                begin
                    p_next   = sat_add(p_reg, best_reg);
                    grp_next = 1'b0;
                end
                else
                begin
                    q_next   = sat_add(q_reg, best_reg);
                    grp_next = 1'b1;
                end
            end
            OP_EMIT:
            begin
                res_next.sorted_value = best_reg;
                res_next.group        = grp_reg;
                res_next.sum_p        = p_reg;
                res_next.sum_q        = q_reg;
                res_next.difference   = (p_reg >= q_reg) ? (p_reg - q_reg) : (q_reg - p_reg);
                res_next.overflow     = dropped_reg;
                res_next.end_of_set   = (i_inc == count_reg);
                valid_next            = 1'b1;
                i_next                = i_inc;
            end
            OP_CLEAR:
            begin
                count_next   = '0;
                i_next       = '0;
                p_next       = '0;
                q_next       = '0;
                dropped_next = 1'b0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= ST_LOAD;
            count_reg   <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            p_reg       <= '0;
            q_reg       <= '0;
            dropped_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            count_reg   <= count_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            p_reg       <= p_next;
            q_reg       <= q_next;
            dropped_reg <= dropped_next;
            valid_reg   <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        vi_reg   <= vi_next;
        bidx_reg <= bidx_next;
        grp_reg  <= grp_next;
        res_reg  <= res_next;
    end

endmodule
